### rtl/sbnp_pkg.sv
// shared types and constants for the signed base-n number parser
// no dependencies; used by sbnp_alpha and signed_base_n_number_parser_top
`timescale 1ns / 1ps

package sbnp_pkg;

    // fixed field widths
    localparam int SYM_W    = 8;
    localparam int RADIX_W  = 5;
    localparam int DIGIT_W  = 4;
    localparam int ALPHA_N  = 16;
    localparam int OUT_W    = 32;
    localparam int APB_W    = 64;
    localparam int PADDR_W  = 5;
    localparam int REG_IDX_W = 2;

    // special characters
    localparam logic [SYM_W-1:0] SYM_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] SYM_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

    // register indexes (byte address = 8 * index)
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIX      = 2'd2;

    // parse phase
    typedef enum logic [1:0] {
        PH_SPACES = 2'd0,
        PH_SIGNS  = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // alphabet lookup result
    typedef struct packed {
        logic               hit;
        logic [DIGIT_W-1:0] digit;
    } t_match;

endpackage

### rtl/sbnp_alpha.sv
// alphabet check and digit lookup against the configured symbol table
// depends on sbnp_pkg
`timescale 1ns / 1ps

module sbnp_alpha #(
    parameter int MAX_RADIX = 16
) (
    input  logic [sbnp_pkg::APB_W-1:0]   i_alpha_low,
    input  logic [sbnp_pkg::APB_W-1:0]   i_alpha_high,
    input  logic [sbnp_pkg::RADIX_W-1:0] i_radix,
    input  logic [sbnp_pkg::SYM_W-1:0]   i_symbol,
    output logic [sbnp_pkg::RADIX_W-1:0] o_radix_use,
    output logic                         o_alpha_ok,
    output sbnp_pkg::t_match             o_match
);

    localparam int HALF_N = sbnp_pkg::ALPHA_N / 2;

    logic [sbnp_pkg::SYM_W-1:0] w_sym [sbnp_pkg::ALPHA_N];
    logic                       w_bad;

    // unpack symbol table
    always_comb begin
        for (int i = 0; i < HALF_N; i++) begin
            w_sym[i]          = i_alpha_low[i*sbnp_pkg::SYM_W +: sbnp_pkg::SYM_W];
            w_sym[i + HALF_N] = i_alpha_high[i*sbnp_pkg::SYM_W +: sbnp_pkg::SYM_W];
        end
    end

    // radix clipped to table size
    assign o_radix_use = (i_radix > sbnp_pkg::RADIX_W'(MAX_RADIX))
                       ? sbnp_pkg::RADIX_W'(MAX_RADIX) : i_radix;

    // validity: radix range, no sign symbols, no repeats
    always_comb begin
        w_bad = (i_radix < sbnp_pkg::RADIX_W'(2))
             || (i_radix > sbnp_pkg::RADIX_W'(MAX_RADIX));
        for (int i = 0; i < MAX_RADIX; i++) begin
            if (sbnp_pkg::RADIX_W'(i) < i_radix) begin
                if (w_sym[i] == sbnp_pkg::SYM_PLUS || w_sym[i] == sbnp_pkg::SYM_MINUS) begin
                    w_bad = 1'b1;
                end
                for (int j = i + 1; j < MAX_RADIX; j++) begin
                    if (sbnp_pkg::RADIX_W'(j) < i_radix && w_sym[j] == w_sym[i]) begin
                        w_bad = 1'b1;
                    end
                end
            end
        end
    end

    assign o_alpha_ok = !w_bad;

    // digit lookup, lowest matching position wins
    always_comb begin
        o_match = '0;
        for (int i = MAX_RADIX - 1; i >= 0; i--) begin
            if (sbnp_pkg::RADIX_W'(i) < o_radix_use && w_sym[i] == i_symbol) begin
                o_match.hit   = 1'b1;
                o_match.digit = sbnp_pkg::DIGIT_W'(i);
            end
        end
    end

endmodule

### rtl/signed_base_n_number_parser_top.sv
// top level of the signed base-n number parser: stream ports, register port,
// parse state and result register; depends on sbnp_pkg and sbnp_alpha
`timescale 1ns / 1ps
//
//  channel   direction  signals                               contents
//  s_axis    in         tvalid tready tdata[7:0] tlast        one string byte, tlast on final byte
//  m_axis    out        tvalid tready tdata[31:0] tuser[0]    parsed value, alphabet ok flag
//  apb       in/out     psel penable pwrite paddr pwdata ...  alphabet low/high at 0x0/0x8, radix 0x10
//
//  one byte per cycle unless a pending result stalls the pipe: once a request is
//  accepted, the lookup and one multiply-add fold it into the parse state when it
//  fires; a final byte loads the result register at that same edge.
//  reset clears the parse state, the registers and both valid flags.
//  a pending result that is not taken stalls the pipe; the input register still
//  takes one request while stalled.

module signed_base_n_number_parser_top #(
    parameter int MAX_RADIX  = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] symbol
    input  logic                           s_axis_tlast,
    // output stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [31:0]                    m_axis_tdata,   // [31:0] value
    output logic [0:0]                     m_axis_tuser,   // [0] alphabet_ok
    // register port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [sbnp_pkg::PADDR_W-1:0]   paddr,
    input  logic [sbnp_pkg::APB_W-1:0]     pwdata,
    output logic [sbnp_pkg::APB_W-1:0]     prdata,
    output logic                           pready
);

    // configuration registers
    logic [sbnp_pkg::APB_W-1:0]   r_alpha_low;
    logic [sbnp_pkg::APB_W-1:0]   r_alpha_high;
    logic [sbnp_pkg::RADIX_W-1:0] r_radix;

    logic [sbnp_pkg::REG_IDX_W-1:0] w_reg_idx;
    logic                           w_cfg_wr;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[sbnp_pkg::PADDR_W-1 -: sbnp_pkg::REG_IDX_W];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_low  <= '0;
            r_alpha_high <= '0;
            r_radix      <= '0;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                sbnp_pkg::REG_ALPHA_LOW:  r_alpha_low  <= pwdata;
                sbnp_pkg::REG_ALPHA_HIGH: r_alpha_high <= pwdata;
                sbnp_pkg::REG_RADIX:      r_radix      <= pwdata[sbnp_pkg::RADIX_W-1:0];
                default: ;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (w_reg_idx)
            sbnp_pkg::REG_ALPHA_LOW:  prdata = r_alpha_low;
            sbnp_pkg::REG_ALPHA_HIGH: prdata = r_alpha_high;
            sbnp_pkg::REG_RADIX:      prdata = sbnp_pkg::APB_W'(r_radix);
            default:                  prdata = '0;
        endcase
    end

    // input register
    logic                       r_in_valid;
    logic [sbnp_pkg::SYM_W-1:0] r_in_symbol;
    logic                       r_in_last;
    logic                       w_adv;
    logic                       w_fire;
    logic                       w_in_acc;

    logic                       r_out_valid;
    logic [31:0]                r_out_value;
    logic                       r_out_ok;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_symbol <= s_axis_tdata[sbnp_pkg::SYM_W-1:0];
            r_in_last   <= s_axis_tlast;
        end
    end

    // alphabet check and lookup
    logic [sbnp_pkg::RADIX_W-1:0] w_radix_use;
    logic                         w_alpha_ok;
    sbnp_pkg::t_match             w_match;

    sbnp_alpha #(
        .MAX_RADIX (MAX_RADIX)
    ) u_alpha (
        .i_alpha_low  (r_alpha_low),
        .i_alpha_high (r_alpha_high),
        .i_radix      (r_radix),
        .i_symbol     (r_in_symbol),
        .o_radix_use  (w_radix_use),
        .o_alpha_ok   (w_alpha_ok),
        .o_match      (w_match)
    );

    // parse state
    sbnp_pkg::t_phase        r_phase, n_phase;
    logic                    r_neg,   n_neg;
    logic [VALUE_BITS-1:0]   r_acc,   n_acc;

    logic                    w_sign_stage;
    logic                    w_dig_stage;
    logic [VALUE_BITS+sbnp_pkg::RADIX_W-1:0] w_prod;
    logic [VALUE_BITS-1:0]   w_mac;
    logic [VALUE_BITS-1:0]   w_signed;
    logic [VALUE_BITS+31:0]  w_ext;

    assign w_prod = r_acc * w_radix_use;
    assign w_mac  = w_prod[VALUE_BITS-1:0] + VALUE_BITS'(w_match.digit);

    // a byte may fall through several phases in one step
    always_comb begin
        w_sign_stage = (r_phase == sbnp_pkg::PH_SIGNS)
                    || (r_phase == sbnp_pkg::PH_SPACES && r_in_symbol != sbnp_pkg::SYM_SPACE);
        w_dig_stage  = (r_phase == sbnp_pkg::PH_DIGITS)
                    || (w_sign_stage && r_in_symbol != sbnp_pkg::SYM_MINUS
                                     && r_in_symbol != sbnp_pkg::SYM_PLUS);
        n_phase = r_phase;
        n_neg   = r_neg;
        n_acc   = r_acc;
        case (r_phase)
            sbnp_pkg::PH_SPACES,
            sbnp_pkg::PH_SIGNS,
            sbnp_pkg::PH_DIGITS: begin
                if (w_dig_stage) begin
                    if (w_match.hit) begin
                        n_phase = sbnp_pkg::PH_DIGITS;
                        n_acc   = w_mac;
                    end else begin
                        n_phase = sbnp_pkg::PH_DONE;
                    end
                end else if (w_sign_stage) begin
                    n_phase = sbnp_pkg::PH_SIGNS;
                    if (r_in_symbol == sbnp_pkg::SYM_MINUS) begin
                        n_neg = !r_neg;
                    end
                end
            end
            sbnp_pkg::PH_DONE: ;
            default: n_phase = sbnp_pkg::PH_SPACES;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sbnp_pkg::PH_SPACES;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (w_fire) begin
            if (r_in_last) begin
                r_phase <= sbnp_pkg::PH_SPACES;
                r_neg   <= 1'b0;
                r_acc   <= '0;
            end else begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
            end
        end
    end

    // signed result, zero when the alphabet is bad
    assign w_signed = !w_alpha_ok ? '0 : (n_neg ? (~n_acc + 1'b1) : n_acc);
    assign w_ext    = {32'b0, w_signed};

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            r_out_value <= w_ext[31:0];
            r_out_ok    <= w_alpha_ok;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = r_out_value;
    assign m_axis_tuser[0] = r_out_ok;

    // checks
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_fire && r_in_last))
        else $error("result appeared without a final byte");

    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_last) |=>
            (r_phase == sbnp_pkg::PH_SPACES && !r_neg && r_acc == '0))
        else $error("parse state not cleared after final byte");

    a_bad_alpha_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_value == 32'd0))
        else $error("nonzero value with invalid alphabet");

    a_done_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == sbnp_pkg::PH_DONE && !(w_fire && r_in_last)) |=>
            (r_phase == sbnp_pkg::PH_DONE))
        else $error("digits resumed after terminator");

endmodule
